### rtl/hrts_pkg.sv
// Shared types and constants for the hysteretic range-table select block.
// No dependencies; every other file depends on this package.
package hrts_pkg;

	localparam int KIND_W      = 1;
	localparam int SLOT_W      = 3;
	localparam int BOUND_W     = 16;
	localparam int VALUE_W     = 16;
	localparam int RANGE_IDX_W = 3;
	localparam int MARGIN_W    = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 10;
	localparam int MAX_SLOTS   = 2 ** SLOT_W;
	localparam int CMP_W       = BOUND_W + 2;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NODATA = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RISE_MARGIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_MARGIN = 1'b1;

	typedef struct packed {
		logic signed [BOUND_W-1:0] lo;
		logic signed [BOUND_W-1:0] hi;
		logic        [VALUE_W-1:0] val;
	} entry_t;

	typedef enum logic [1:0] {
		CMP_PLAIN,
		CMP_RISE,
		CMP_FALL
	} cmp_op_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} cmp_res_t;

endpackage

### rtl/hrts_in_if.sv
// Input channel: table loads and samples with valid/ready handshake.
// Depends on hrts_pkg for field widths.
interface hrts_in_if;
	logic                               valid;
	logic                               ready;
	logic [hrts_pkg::KIND_W-1:0]        kind;
	logic [hrts_pkg::SLOT_W-1:0]        entry_slot;
	logic signed [hrts_pkg::BOUND_W-1:0] entry_low;
	logic signed [hrts_pkg::BOUND_W-1:0] entry_high;
	logic [hrts_pkg::VALUE_W-1:0]       entry_value;
	logic signed [hrts_pkg::BOUND_W-1:0] sample;

	modport source (output valid, kind, entry_slot, entry_low, entry_high, entry_value,
		sample, input ready);
	modport sink (input valid, kind, entry_slot, entry_low, entry_high, entry_value,
		sample, output ready);
endinterface

### rtl/hrts_out_if.sv
// Result channel: selected range with valid/ready handshake.
// Depends on hrts_pkg for field widths.
interface hrts_out_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic [hrts_pkg::RANGE_IDX_W-1:0]  range_index;
	logic [hrts_pkg::VALUE_W-1:0]      value;
	logic                              changed;

	modport source (output valid, status, range_index, value, changed, input ready);
	modport sink (input valid, status, range_index, value, changed, output ready);
endinterface

### rtl/hrts_cfg_if.sv
// Configuration write channel: register index and data, valid/ready.
// Depends on hrts_pkg for field widths.
interface hrts_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hrts_pkg::CFG_IDX_W-1:0]   index;
	logic [hrts_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/hrts_table.sv
// Range table storage: one write port, one read port, cleared at reset.
// Depends on hrts_pkg.
module hrts_table #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [hrts_pkg::SLOT_W-1:0]   wslot,
	input  hrts_pkg::entry_t              wdata,
	input  logic [IDX_W-1:0]              raddr,
	output hrts_pkg::entry_t              rdata
);
	import hrts_pkg::*;

	entry_t tbl_q [DEPTH];
	logic   slot_ok;

	// slots past the table depth are dropped
	assign slot_ok = 32'(wslot) < DEPTH;
	assign rdata   = tbl_q[raddr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (we && slot_ok) begin
			tbl_q[wslot[IDX_W-1:0]] <= wdata;
		end
	end
endmodule

### rtl/hrts_cmp.sv
// Shared compare unit: (a + signed margin) against b, gives gt and lt.
// Depends on hrts_pkg.
module hrts_cmp (
	input  hrts_pkg::cmp_op_t                   op,
	input  logic signed [hrts_pkg::BOUND_W-1:0] a,
	input  logic signed [hrts_pkg::BOUND_W-1:0] b,
	input  logic [hrts_pkg::MARGIN_W-1:0]       rise_margin,
	input  logic [hrts_pkg::MARGIN_W-1:0]       fall_margin,
	output hrts_pkg::cmp_res_t                  res
);
	import hrts_pkg::*;

	logic signed [CMP_W-1:0] a_x;
	logic signed [CMP_W-1:0] b_x;
	logic signed [CMP_W-1:0] off;
	logic signed [CMP_W-1:0] sum;

	always_comb begin
		a_x = CMP_W'(a);
		b_x = CMP_W'(b);
		case (op)
			CMP_RISE: off = $signed({{(CMP_W-MARGIN_W){1'b0}}, rise_margin});
			CMP_FALL: off = -$signed({{(CMP_W-MARGIN_W){1'b0}}, fall_margin});
			default:  off = '0;
		endcase
		sum    = a_x + off;
		res.gt = sum > b_x;
		res.lt = sum < b_x;
	end
endmodule

### rtl/hysteretic_range_table_select_core.sv
// Top level of the hysteretic range-table select block: sequencer, margins,
// result register. Depends on hrts_pkg, the hrts_*_if interfaces,
// hrts_table and hrts_cmp.
//  - in_ch carries transactions of two kinds. A load (kind 0) writes one
//    table slot in the cycle it is accepted and produces no result; the
//    block is ready again on the next cycle. A sample (kind 1) produces
//    exactly one result transaction on out_ch.
//  - A sample walks the table through a single shared comparator: for each
//    scanned entry a lower-bound step, then an upper-bound step where needed;
//    then the hysteresis check and the value read. With no data at slot 0
//    the scan goes straight to the value read. The table holds
//    N = min(NUM_RANGES, 8) entries. in_ch.ready is low while a sample is
//    in progress.
//  - The result sits in an output register. in_ch is ready again as soon as
//    that register is loaded; if the receiver stalls and the register is
//    still full when the next sample is done, the sequencer holds until it drains.
//  - cfg writes rise_margin (index 0) and fall_margin (index 1); always ready.
//    Write only while the block is idle.
//  - arst_n clears the table to all zero, the selected range to none, the
//    margins to zero and drops any pending result.
module hysteretic_range_table_select_core #(
	parameter int NUM_RANGES = 8
) (
	input logic      clk,
	input logic      arst_n,
	hrts_in_if.sink  in_ch,
	hrts_out_if.source out_ch,
	hrts_cfg_if.sink cfg
);
	import hrts_pkg::*;

	// only slots reachable by entry_slot can ever be nonzero; the rest read as
	// the end mark, so storage stops there
	localparam int TBL_DEPTH = (NUM_RANGES < MAX_SLOTS) ? NUM_RANGES : MAX_SLOTS;
	localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_HYST,
		ST_VAL
	} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           ptr_q;
	logic                       nodata_q;
	logic signed [BOUND_W-1:0]  sample_q;
	logic                       cur_valid_q;
	logic [IDX_W-1:0]           cur_q;
	logic [MARGIN_W-1:0]        rise_q;
	logic [MARGIN_W-1:0]        fall_q;

	logic                       out_valid_q;
	logic                       status_q;
	logic [RANGE_IDX_W-1:0]     idx_q;
	logic [VALUE_W-1:0]         value_q;
	logic                       changed_q;

	logic                       in_acc;
	logic                       tbl_we;
	entry_t                     wentry;
	entry_t                     rd;
	logic                       rd_zero;
	logic                       step_up;
	logic                       step_down;
	logic                       last_ent;
	logic                       out_free;
	cmp_op_t                    cmp_op;
	logic signed [BOUND_W-1:0]  cmp_a;
	cmp_res_t                   cmp;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign tbl_we      = in_acc && (in_ch.kind == KIND_LOAD);
	assign cfg.ready   = 1'b1;

	assign wentry.lo  = in_ch.entry_low;
	assign wentry.hi  = in_ch.entry_high;
	assign wentry.val = in_ch.entry_value;

	hrts_table #(
		.DEPTH(TBL_DEPTH),
		.IDX_W(IDX_W)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.wslot (in_ch.entry_slot),
		.wdata (wentry),
		.raddr (ptr_q),
		.rdata (rd)
	);

	// end mark: both bounds zero
	assign rd_zero  = (rd.lo == '0) && (rd.hi == '0);
	assign last_ent = (ptr_q == LAST_IDX);
	assign out_free = !out_valid_q || out_ch.ready;

	// hysteresis only for a move of exactly one range from a held range
	assign step_up   = cur_valid_q && (({1'b0, cur_q} + 1'b1) == {1'b0, ptr_q});
	assign step_down = cur_valid_q && (({1'b0, ptr_q} + 1'b1) == {1'b0, cur_q});

	// operand select for the shared comparator
	always_comb begin
		cmp_op = CMP_PLAIN;
		cmp_a  = rd.lo;
		case (state_q)
			ST_HI: cmp_a = rd.hi;
			ST_HYST: begin
				if (step_up) begin
					cmp_op = CMP_RISE;
					cmp_a  = rd.lo;
				end else begin
					cmp_op = CMP_FALL;
					cmp_a  = rd.hi;
				end
			end
			default: cmp_a = rd.lo;
		endcase
	end

	hrts_cmp u_cmp (
		.op         (cmp_op),
		.a          (cmp_a),
		.b          (sample_q),
		.rise_margin(rise_q),
		.fall_margin(fall_q),
		.res        (cmp)
	);

	// margin registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			fall_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RISE_MARGIN: rise_q <= cfg.data[MARGIN_W-1:0];
				REG_FALL_MARGIN: fall_q <= cfg.data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			nodata_q    <= 1'b0;
			sample_q    <= '0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_OK;
			idx_q       <= '0;
			value_q     <= '0;
			changed_q   <= 1'b0;
		end else begin
			// the value step reloads the result register itself
			if (out_ch.ready && (state_q != ST_VAL)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_ch.kind == KIND_SAMPLE)) begin
						sample_q <= in_ch.sample;
						ptr_q    <= '0;
						nodata_q <= 1'b0;
						state_q  <= ST_LO;
					end
				end
				ST_LO: begin
					// lower bound check; sample below slot 0 or slot 0 empty -> no data
					if ((ptr_q == '0) && (cmp.gt || rd_zero)) begin
						nodata_q <= 1'b1;
						state_q  <= ST_VAL;
					end else if (rd_zero) begin
						// ran off the valid entries: clip to the last one
						ptr_q   <= ptr_q - 1'b1;
						state_q <= ST_HYST;
					end else if (!cmp.gt) begin
						state_q <= ST_HI;
					end else if (last_ent) begin
						state_q <= ST_HYST;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_HI: begin
					if (!cmp.lt || last_ent) begin
						state_q <= ST_HYST;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_LO;
					end
				end
				ST_HYST: begin
					if ((step_up && cmp.gt) || (step_down && !step_up && cmp.lt)) begin
						ptr_q <= cur_q;
					end
					state_q <= ST_VAL;
				end
				ST_VAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (nodata_q) begin
							status_q    <= STATUS_NODATA;
							idx_q       <= '0;
							value_q     <= '0;
							changed_q   <= 1'b0;
							cur_valid_q <= 1'b0;
						end else begin
							status_q    <= STATUS_OK;
							idx_q       <= RANGE_IDX_W'(ptr_q);
							value_q     <= rd.val;
							changed_q   <= !cur_valid_q || (cur_q != ptr_q);
							cur_valid_q <= 1'b1;
							cur_q       <= ptr_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.range_index = idx_q;
	assign out_ch.value       = value_q;
	assign out_ch.changed     = changed_q;

	// a sample transaction closes the input side in the cycle after it is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.kind == KIND_SAMPLE)) |=> !in_ch.ready)
		else $error("input reopened right after a sample transaction");

	// a no-data result carries zero index, zero value and no change flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STATUS_NODATA)) |->
		((idx_q == '0) && (value_q == '0) && !changed_q))
		else $error("no-data result with nonzero payload");

	// the scan pointer never leaves the stored table
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ptr_q) < TBL_DEPTH) && (32'(cur_q) < TBL_DEPTH))
		else $error("table pointer out of range");

	// a result is only loaded from the value step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_VAL))
		else $error("result produced outside the value step");
endmodule
